/* hdl/mdmq_pkg.sv */
// shared types and constants for the multiply/divide unit with mq
package mdmq_pkg;

	typedef enum logic [2:0] {
		OP_DIVW  = 3'd0,
		OP_DIVWU = 3'd1,
		OP_DOZ   = 3'd2,
		OP_MUL   = 3'd3,
		OP_DIV   = 3'd4,
		OP_DIVS  = 3'd5,
		OP_SETMQ = 3'd6,
		OP_NOP   = 3'd7
	} op_t;

	localparam logic [31:0] SIGN32 = 32'h8000_0000;
	localparam logic [31:0] ALL32  = 32'hFFFF_FFFF;
	localparam int unsigned STEPS  = 64;
	localparam int unsigned IN_W   = 72;
	localparam int unsigned OUT_W  = 72;

	typedef struct packed {
		logic [31:0] result;
		logic        result_write;
		logic        ov_write;
		logic        ov_value;
		logic        cr0_write;
		logic [3:0]  cr0_field;
		logic [31:0] mq_value;
	} res_t;

	function automatic logic [3:0] cr0_of(input logic [31:0] v, input logic so);
		logic [2:0] c;
		begin
			if (v[31])
				c = 3'b100;
			else if (v != 32'd0)
				c = 3'b010;
			else
				c = 3'b001;
			cr0_of = {c, so};
		end
	endfunction

endpackage

/* hdl/multiply_divide_mq_unit.sv */
// Integer multiply/divide unit with the MQ register: one instruction per input beat, one result
// beat each. doz, set mq and unused code 7 finish right away: the result beat can be taken in
// the cycle after the input beat. mul, divw, divwu, div and divs run one shared 65-bit adder
// and shift datapath one bit per cycle: mul steps through the multiplier bits, the divides
// run a restoring divide on the 64-bit magnitude, then a finish state writes the output
// register. The input is ready only while the unit is idle, which is again the cycle after
// the result beat is taken; a finished result sits in the output register until taken.
module multiply_divide_mq_unit import mdmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[2:0], operand_a[34:3], operand_b[66:35], overflow_enable[67],
	// record_enable[68], summary_overflow_in[69], zero fill
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result[31:0], result_write[32], ov_write[33], ov_value[34], cr0_write[35],
	// cr0_field[39:36], mq_value[71:40]
	output logic [71:0] m_tdata
);

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN, ST_OUT} state_t;

	state_t      state_q;
	op_t         op_q;
	logic [31:0] mq_q;
	logic        oe_q, rc_q, so_q;
	logic [63:0] acc_q;    // mul: multiplier bits; div: dividend magnitude shifting into quotient
	logic [63:0] rem_q;    // partial remainder, or the mul product
	logic [63:0] dsr_q;    // divisor magnitude (or multiplicand)
	logic        dneg_q, qneg_q, bz_q;
	logic [6:0]  cnt_q;
	res_t        res_q;

	// decoded input
	op_t         in_op;
	logic [31:0] in_a, in_b;
	assign in_op = op_t'(s_tdata[2:0]);
	assign in_a  = s_tdata[34:3];
	assign in_b  = s_tdata[66:35];

	// shared 65-bit adder
	logic [63:0] rem_sh;
	logic [64:0] alu_x, alu_y, alu_s;
	logic        alu_c;
	assign rem_sh = {rem_q[62:0], acc_q[63]};
	always_comb begin
		alu_x = {1'b0, rem_q};
		alu_y = 65'd0;
		alu_c = 1'b0;
		if (state_q == ST_DIV) begin
			alu_x = {1'b0, rem_sh};
			alu_y = ~{1'b0, dsr_q};
			alu_c = 1'b1;
		end else if (acc_q[0]) begin
			// top multiplier bit has negative weight
			if (cnt_q == 7'd31) begin
				alu_y = ~{1'b0, dsr_q};
				alu_c = 1'b1;
			end else begin
				alu_y = {1'b0, dsr_q};
			end
		end
	end
	assign alu_s = alu_x + alu_y + {64'd0, alu_c};

	// setup values
	logic [63:0] dd_in, ud_in, ub_in;
	logic        dneg_in, bneg_in;
	always_comb begin
		if (in_op == OP_DIV)
			dd_in = {in_a, mq_q};
		else if (in_op == OP_DIVWU)
			dd_in = {32'd0, in_a};
		else
			dd_in = {{32{in_a[31]}}, in_a};
		dneg_in = (in_op != OP_DIVWU) && dd_in[63];
		bneg_in = (in_op != OP_DIVWU) && in_b[31];
		ud_in   = dneg_in ? (~dd_in) + 64'd1 : dd_in;
		ub_in   = {32'd0, bneg_in ? (~in_b) + 32'd1 : in_b};
	end

	// ST_FIN values: div acc_q quotient, rem_q remainder magnitudes; mul rem_q product
	logic [31:0] qv, rv, fin_r, fin_mq, cr_src;
	logic        fits, fin_ov;
	logic [63:0] pm;
	always_comb begin
		qv   = qneg_q ? 32'd0 - acc_q[31:0] : acc_q[31:0];
		rv   = dneg_q ? 32'd0 - rem_q[31:0] : rem_q[31:0];
		fits = qneg_q ? (acc_q <= 64'h8000_0000) : (acc_q <= 64'h7FFF_FFFF);
		pm   = rem_q;
		fin_r  = 32'd0;
		fin_mq = mq_q;
		fin_ov = 1'b0;
		case (op_q)
			OP_DIVW: begin
				if (bz_q || !fits)
					fin_ov = 1'b1;
				else
					fin_r = qv;
			end
			OP_DIVWU: begin
				if (bz_q)
					fin_ov = 1'b1;
				else
					fin_r = acc_q[31:0];
			end
			OP_MUL: begin
				fin_r  = pm[63:32];
				fin_mq = pm[31:0];
				fin_ov = (pm[63:32] != {32{pm[31]}});
			end
			OP_DIV, OP_DIVS: begin
				if (bz_q) begin
					fin_mq = 32'd0;
					fin_ov = 1'b1;
				end else if (!fits) begin
					fin_r  = SIGN32;
					fin_mq = 32'd0;
					fin_ov = 1'b1;
				end else begin
					fin_r  = qv;
					fin_mq = rv;
				end
			end
			default: ;
		endcase
		cr_src = (op_q == OP_MUL || op_q == OP_DIV || op_q == OP_DIVS) ? fin_mq : fin_r;
	end

	// doz and immediate ops
	logic [31:0] doz_r;
	logic        doz_ov, doz_gt;
	assign doz_gt = (in_a ^ SIGN32) > (in_b ^ SIGN32);
	assign doz_r  = doz_gt ? 32'd0 : in_b - in_a;
	assign doz_ov = !doz_gt && (((in_a ^ in_b) & (doz_r ^ in_b)) >> 31 != 32'd0);

	logic in_oe, in_rc, in_so;
	assign in_oe = s_tdata[67];
	assign in_rc = s_tdata[68];
	assign in_so = s_tdata[69];

	res_t imm_res;
	always_comb begin
		imm_res = '0;
		imm_res.mq_value = mq_q;
		case (in_op)
			OP_DOZ: begin
				imm_res.result       = doz_r;
				imm_res.result_write = 1'b1;
				imm_res.ov_write     = in_oe;
				imm_res.ov_value     = in_oe & doz_ov;
				imm_res.cr0_write    = in_rc;
				imm_res.cr0_field    = in_rc ? cr0_of(doz_r, in_so | (in_oe & doz_ov)) : 4'd0;
			end
			OP_SETMQ: imm_res.mq_value = in_a;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mq_q    <= 32'd0;
			cnt_q   <= 7'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q   <= in_op;
						oe_q   <= in_oe;
						rc_q   <= in_rc;
						so_q   <= in_so;
						bz_q   <= (in_b == 32'd0);
						dneg_q <= dneg_in;
						qneg_q <= dneg_in != bneg_in;
						rem_q  <= 64'd0;
						cnt_q  <= 7'd0;
						res_q  <= imm_res;
						case (in_op)
							OP_DOZ: state_q <= ST_OUT;
							OP_SETMQ: begin
								mq_q <= in_a;
								state_q <= ST_OUT;
							end
							OP_MUL: begin
								acc_q   <= {32'd0, in_b};
								dsr_q   <= {{32{in_a[31]}}, in_a};
								state_q <= ST_MUL;
							end
							OP_DIVW, OP_DIVWU, OP_DIV, OP_DIVS: begin
								acc_q   <= ud_in;
								dsr_q   <= ub_in;
								state_q <= ST_DIV;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_MUL: begin
					// shift-add on the multiplier bits
					rem_q <= alu_s[63:0];
					dsr_q <= {dsr_q[62:0], 1'b0};
					acc_q <= {1'b0, acc_q[63:1]};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd31) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (!alu_s[64]) begin
						rem_q <= alu_s[63:0];
						acc_q <= {acc_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						acc_q <= {acc_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					mq_q <= fin_mq;
					res_q.result       <= fin_r;
					res_q.result_write <= 1'b1;
					res_q.ov_write     <= oe_q;
					res_q.ov_value     <= oe_q & fin_ov;
					res_q.cr0_write    <= rc_q;
					res_q.cr0_field    <= rc_q ? cr0_of(cr_src, so_q | (oe_q & fin_ov)) : 4'd0;
					res_q.mq_value     <= fin_mq;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {res_q.mq_value, res_q.cr0_field, res_q.cr0_write, res_q.ov_value,
		res_q.ov_write, res_q.result_write, res_q.result};

endmodule

/* hdl/mdmq_checker.sv */
// port-level checks for the multiply/divide unit, bound to the top level
module mdmq_unit_assertions import mdmq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [71:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("input ready while result pending");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("ready right after accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped or changed under stall");

	a_unwritten_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[32]) |-> (m_tdata[39:0] == 40'd0))
		else $error("fields set without rD write");

	a_cr0_gate: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[35]) |-> (m_tdata[39:36] == 4'd0))
		else $error("cr0 field without cr0 write");

endmodule

bind multiply_divide_mq_unit mdmq_unit_assertions u_mdmq_checker (.*);

/* bench/mdmq_checker.sv */
// result checker for the multiply/divide unit: predicts each output beat from the input beats
module mdmq_checker import mdmq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [71:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	output int          fail_count,
	output int          pending
);

	logic [31:0] mq_shadow;
	res_t        expected_q[$];

	function automatic logic [3:0] cr0_bits(input logic [31:0] v, input logic so);
		logic [3:0] c;
		begin
			if (v[31])
				c = 4'b1000;
			else if (v != 32'd0)
				c = 4'b0100;
			else
				c = 4'b0010;
			c[0] = so;
			return c;
		end
	endfunction

	// signed 64 by 32 divide; returns 1 when the quotient fits 32 signed bits
	function automatic logic sdiv(input logic [63:0] dd, input logic [31:0] b,
			output logic [31:0] q, output logic [31:0] rm);
		logic        dneg, bneg, qneg;
		logic [63:0] ud, ub, uq, ur;
		begin
			dneg = dd[63];
			bneg = b[31];
			qneg = dneg ^ bneg;
			ud = dneg ? -dd : dd;
			ub = bneg ? {32'd0, -b} : {32'd0, b};
			uq = ud / ub;
			ur = ud % ub;
			q = qneg ? -uq[31:0] : uq[31:0];
			rm = dneg ? -ur[31:0] : ur[31:0];
			return qneg ? (uq <= 64'h8000_0000) : (uq <= 64'h7FFF_FFFF);
		end
	endfunction

	function automatic res_t predict_instr(input logic [71:0] d, inout logic [31:0] mq);
		op_t         op;
		logic [31:0] a, b, r, crsrc, q, rm;
		logic        oe, rc, so, ov, wr, ovv;
		logic [63:0] p, dd;
		res_t        o;
		begin
			op = op_t'(d[2:0]);
			a = d[34:3];
			b = d[66:35];
			oe = d[67];
			rc = d[68];
			so = d[69];
			r = '0;
			ov = 1'b0;
			crsrc = '0;
			wr = 1'b1;
			case (op)
				OP_DIVW: begin
					if (b == 0 || !sdiv({{32{a[31]}}, a}, b, q, rm)) begin
						r = '0;
						ov = 1'b1;
					end else begin
						r = q;
					end
					crsrc = r;
				end
				OP_DIVWU: begin
					if (b == 0) begin
						ov = 1'b1;
					end else begin
						r = a / b;
					end
					crsrc = r;
				end
				OP_DOZ: begin
					if ((a ^ SIGN32) <= (b ^ SIGN32)) begin
						r = b - a;
						ov = (a[31] ^ b[31]) & (r[31] ^ b[31]);
					end
					crsrc = r;
				end
				OP_MUL: begin
					p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
					mq = p[31:0];
					r = p[63:32];
					ov = (p != {{32{mq[31]}}, mq});
					crsrc = mq;
				end
				OP_DIV, OP_DIVS: begin
					dd = (op == OP_DIV) ? {a, mq} : {{32{a[31]}}, a};
					if (b == 0) begin
						mq = '0;
						ov = 1'b1;
					end else if (!sdiv(dd, b, q, rm)) begin
						r = SIGN32;
						mq = '0;
						ov = 1'b1;
					end else begin
						r = q;
						mq = rm;
					end
					crsrc = mq;
				end
				OP_SETMQ: begin
					mq = a;
					wr = 1'b0;
				end
				default: wr = 1'b0;
			endcase
			o = '0;
			if (wr) begin
				ovv = oe & ov;
				o.result = r;
				o.result_write = 1'b1;
				o.ov_write = oe;
				o.ov_value = ovv;
				o.cr0_write = rc;
				o.cr0_field = rc ? cr0_bits(crsrc, so | ovv) : 4'd0;
			end
			o.mq_value = mq;
			return o;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want, got;
		if (!arst_n) begin
			mq_shadow <= '0;
			fail_count <= 0;
			expected_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				logic [31:0] mq_next;
				mq_next = mq_shadow;
				expected_q.push_back(predict_instr(s_tdata, mq_next));
				mq_shadow <= mq_next;
			end
			if (m_tvalid && m_tready) begin
				got.result       = m_tdata[31:0];
				got.result_write = m_tdata[32];
				got.ov_write     = m_tdata[33];
				got.ov_value     = m_tdata[34];
				got.cr0_write    = m_tdata[35];
				got.cr0_field    = m_tdata[39:36];
				got.mq_value     = m_tdata[71:40];
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = expected_q.size();

endmodule

/* bench/tb_multiply_divide_mq_unit.sv */
// testbench top: stimulus, stalls and verdict for the multiply/divide unit
module tb_multiply_divide_mq_unit;
	import mdmq_pkg::*;

	localparam int WATCHDOG = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	int          fail_count, pending;
	int          idle_cycles = 0;
	logic        stim_done = 1'b0;

	always #5 clk = ~clk;

	multiply_divide_mq_unit u_top (.*);

	mdmq_checker u_chk (.*);

	function automatic int gap_len();
		int k;
		begin
			k = $urandom_range(0, 99);
			if (k < 40) return 0;
			if (k < 92) return $urandom_range(1, 4);
			return $urandom_range(10, 90);
		end
	endfunction

	function automatic logic [31:0] rand_word();
		begin
			case ($urandom_range(0, 7))
				0: return 32'd0;
				1: return SIGN32;
				2: return ALL32;
				3: return $urandom_range(0, 15);
				4: return -$urandom_range(1, 15);
				5: return 32'h7FFF_FFFF;
				default: return $urandom;
			endcase
		end
	endfunction

	// valid drops only when a gap follows, so no two drives land in one step
	task automatic send_instr(input op_t op, input logic [31:0] a, input logic [31:0] b,
			input logic [2:0] flags);
		int g;
		begin
			g = gap_len();
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= {2'b00, flags, b, a, op};
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
	endtask

	// receiver stalls
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		op_t op;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed corners
		send_instr(OP_DIVW, 32'd7, 32'd0, 3'b011);
		send_instr(OP_DIVW, SIGN32, ALL32, 3'b111);
		send_instr(OP_DIVW, -32'd7, 32'd2, 3'b010);
		send_instr(OP_DIVWU, ALL32, 32'd1, 3'b011);
		send_instr(OP_DIVWU, 32'd5, 32'd0, 3'b001);
		send_instr(OP_DOZ, 32'h7FFF_FFFF, SIGN32, 3'b011);
		send_instr(OP_DOZ, SIGN32, 32'h7FFF_FFFF, 3'b011);
		send_instr(OP_DOZ, 32'd5, 32'd2, 3'b111);
		send_instr(OP_MUL, SIGN32, SIGN32, 3'b011);
		send_instr(OP_MUL, ALL32, 32'd3, 3'b010);
		send_instr(OP_SETMQ, 32'h1234_5678, ALL32, 3'b111);
		send_instr(OP_DIV, 32'd0, 32'd10, 3'b011);
		send_instr(OP_SETMQ, 32'd0, 32'd0, 3'b000);
		send_instr(OP_DIV, 32'h0000_0001, 32'd1, 3'b011);
		send_instr(OP_DIV, ALL32, 32'd0, 3'b111);
		send_instr(OP_SETMQ, ALL32, 32'd0, 3'b000);
		send_instr(OP_DIV, ALL32, 32'd3, 3'b011);
		send_instr(OP_DIVS, SIGN32, ALL32, 3'b011);
		send_instr(OP_DIVS, -32'd7, 32'd2, 3'b010);
		send_instr(OP_DIVS, 32'd9, 32'd0, 3'b011);
		send_instr(OP_NOP, ALL32, ALL32, 3'b111);
		send_instr(OP_DIVW, ALL32, ALL32, 3'b000);
		for (int i = 0; i < 1500; i++) begin
			op = op_t'($urandom_range(0, 7));
			send_instr(op, rand_word(), rand_word(), 3'($urandom));
		end
		s_tvalid <= 1'b0;
		stim_done <= 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
